[design/bsrit_pkg.sv]
// ----------------------------------------------------------------------------
// bsrit_pkg
// Shared sizes, codes and the row table entry of the block sparse row index
// table unit.
// ----------------------------------------------------------------------------
package bsrit_pkg;

    localparam int MAX_ROWS       = 1024;
    localparam int BLOCK_CAPACITY = 16384;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int SLOT_W  = $clog2(BLOCK_CAPACITY);
    localparam int CNT_W   = $clog2(BLOCK_CAPACITY + 1);
    localparam int BS_W    = 4;
    localparam int BSQ_W   = 7;
    localparam int OUT_SLOT_W  = 14;
    localparam int OFFSET_W    = 20;
    localparam int OUT_COUNT_W = 15;
    localparam int PROD_W  = OUT_SLOT_W + BSQ_W;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [ROW_W:0]     ROW_LIMIT   = (ROW_W + 1)'(MAX_ROWS);
    localparam logic [CNT_W-1:0]   BLOCK_LIMIT = CNT_W'(BLOCK_CAPACITY);
    localparam logic [ROW_AW-1:0]  LAST_ROW    = ROW_AW'(MAX_ROWS - 1);
    localparam logic [PROD_W-1:0]  OFFSET_MAX  = PROD_W'((1 << OFFSET_W) - 1);
    localparam logic [BS_W-1:0]    BS_RESET    = 4'd3;
    localparam logic [BSQ_W-1:0]   BSQ_RESET   = 7'd9;
    localparam logic [BSQ_W-1:0]   BS_CLAMP    = 7'd8;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [ADDR_W-3:0] REG_BLOCK_SIZE = '0;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_ORDER     = 2'd3;

    typedef struct packed {
        logic             used;
        logic [CNT_W-1:0] start_slot;
        logic [CNT_W-1:0] stop_slot;
    } row_entry_t;

    localparam int ROW_ENTRY_W = $bits(row_entry_t);

endpackage

[design/bsrit_ifs.sv]
// ----------------------------------------------------------------------------
// bsrit channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface bsrit_req_if
    import bsrit_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;

    modport source (output valid, output operation, output row, output column, input ready);
    modport sink   (input valid, input operation, input row, input column, output ready);
endinterface

interface bsrit_rsp_if
    import bsrit_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [OUT_SLOT_W-1:0]  slot;
    logic [OFFSET_W-1:0]    value_offset;
    logic [OUT_COUNT_W-1:0] block_count;

    modport source (output valid, output status, output slot, output value_offset,
                    output block_count, input ready);
    modport sink   (input valid, input status, input slot, input value_offset,
                    input block_count, output ready);
endinterface

[design/bsrit_ram.sv]
// ----------------------------------------------------------------------------
// bsrit_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read, enabled by re.
// ----------------------------------------------------------------------------
module bsrit_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/block_sparse_row_index_table_unit.sv]
// ----------------------------------------------------------------------------
// block_sparse_row_index_table_unit
// Index engine for a block compressed sparse row matrix: appends block
// columns to rows and looks up the slot and value offset of a block.
//
//   Channel   Role    Beat contents
//   req       sink    operation, row, column
//   rsp       source  status, slot, value_offset, block_count
//   APB       slave   block_size register at byte address 0
//
// Once its request beat is accepted, a push passes S_PUSH and S_DONE, a
// lookup S_LOOK_ROW, S_LOOK_START, S_SCAN and S_DONE, and a lookup of a row
// never pushed skips S_SCAN; in S_SCAN the column store read port delivers
// one stored column per cycle. S_DONE loads the result register once the
// previous result is taken, and the next request beat is then accepted even
// while that result waits. After reset a clearing pass clears the row table
// while no request is accepted; register writes are taken throughout.
// ----------------------------------------------------------------------------
module block_sparse_row_index_table_unit
    import bsrit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bsrit_req_if.sink         req,
    bsrit_rsp_if.source       rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PUSH,
        S_LOOK_ROW,
        S_LOOK_START,
        S_SCAN,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [ROW_AW-1:0]    clr_cnt_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [CNT_W-1:0]     stored_reg;
    logic [ROW_W-1:0]     cur_row_reg;
    logic [CNT_W-1:0]     cur_start_reg;
    logic                 any_pushed_reg;
    logic [CNT_W-1:0]     p_reg;
    logic [CNT_W-1:0]     e_reg;
    logic                 cmp_valid_reg;
    logic [SLOT_W-1:0]    cmp_slot_reg;
    logic [1:0]           res_status_reg;
    logic [OUT_SLOT_W-1:0] res_slot_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [OUT_SLOT_W-1:0] out_slot_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg;
    logic [BS_W-1:0]      block_size_reg;
    logic [BSQ_W-1:0]     bsq_reg;

    logic                 rt_we;
    logic [ROW_AW-1:0]    rt_waddr;
    row_entry_t           rt_wdata;
    row_entry_t           rt_rdata;
    logic [ROW_ENTRY_W-1:0] rt_rdata_raw;
    logic                 cs_we;
    logic                 cs_re;
    logic [COL_W-1:0]     cs_rdata;

    logic                 rej_order;
    logic                 store_full;
    logic                 same_row;
    logic                 row_in_range;
    logic [PROD_W-1:0]    prod;
    logic [OFFSET_W-1:0]  offset_sat;
    logic [BSQ_W-1:0]     bs_clamp;
    logic [BSQ_W-1:0]     bsq_next;
    logic                 cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_BLOCK_SIZE);
    assign prdata    = (paddr[ADDR_W-1:2] == REG_BLOCK_SIZE) ?
                       {{(DATA_W - BS_W){1'b0}}, block_size_reg} : '0;
    assign bs_clamp  = ({3'b000, pwdata[BS_W-1:0]} > BS_CLAMP) ?
                       BS_CLAMP : {3'b000, pwdata[BS_W-1:0]};
    assign bsq_next  = BSQ_W'(bs_clamp * bs_clamp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BS_RESET;
            bsq_reg        <= BSQ_RESET;
        end
        else if (cfg_write)
        begin
            block_size_reg <= pwdata[BS_W-1:0];
            bsq_reg        <= bsq_next;
        end
    end

    // Push checks on the captured request.
    assign row_in_range = {1'b0, row_reg} < ROW_LIMIT;
    assign same_row     = any_pushed_reg && (row_reg == cur_row_reg);
    assign rej_order    = !row_in_range || (any_pushed_reg && (row_reg < cur_row_reg));
    assign store_full   = stored_reg >= BLOCK_LIMIT;

    // Memory port control.
    always_comb
    begin
        rt_we    = 1'b0;
        rt_waddr = row_reg[ROW_AW-1:0];
        rt_wdata = '{used: 1'b1,
                     start_slot: same_row ? cur_start_reg : stored_reg,
                     stop_slot: CNT_W'(stored_reg + 1'b1)};
        if (state_reg == S_CLEAR)
        begin
            rt_we    = 1'b1;
            rt_waddr = clr_cnt_reg;
            rt_wdata = '0;
        end
        else if (state_reg == S_PUSH && !rej_order && !store_full)
        begin
            rt_we = 1'b1;
        end
    end

    assign cs_we    = (state_reg == S_PUSH) && !rej_order && !store_full;
    assign cs_re    = (state_reg == S_SCAN) && (p_reg < e_reg);
    assign rt_rdata = row_entry_t'(rt_rdata_raw);

    bsrit_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (ROW_ENTRY_W)
    ) u_row_table (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .re    (state_reg == S_LOOK_ROW),
        .raddr (row_reg[ROW_AW-1:0]),
        .rdata (rt_rdata_raw)
    );

    bsrit_ram #(
        .DEPTH (BLOCK_CAPACITY),
        .WIDTH (COL_W)
    ) u_col_store (
        .clk   (clk),
        .we    (cs_we),
        .waddr (stored_reg[SLOT_W-1:0]),
        .wdata (col_reg),
        .re    (cs_re),
        .raddr (p_reg[SLOT_W-1:0]),
        .rdata (cs_rdata)
    );

    // Value offset: slot times block size (clamped to 8) squared, saturated.
    assign prod       = res_slot_reg * bsq_reg;
    assign offset_sat = (prod > OFFSET_MAX) ? '1 : prod[OFFSET_W-1:0];

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.slot         = out_slot_reg;
    assign rsp.value_offset = out_offset_reg;
    assign rsp.block_count  = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            stored_reg     <= '0;
            cur_row_reg    <= '0;
            cur_start_reg  <= '0;
            any_pushed_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rsp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == LAST_ROW)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        row_reg   <= req.row;
                        col_reg   <= req.column;
                        state_reg <= (req.operation == OP_LOOKUP) ? S_LOOK_ROW : S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    state_reg <= S_DONE;
                    if (rej_order)
                    begin
                        res_status_reg <= ST_ORDER;
                        res_slot_reg   <= '0;
                    end
                    else if (store_full)
                    begin
                        res_status_reg <= ST_FULL;
                        res_slot_reg   <= '0;
                    end
                    else
                    begin
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= OUT_SLOT_W'(stored_reg);
                        stored_reg     <= stored_reg + 1'b1;
                        cur_row_reg    <= row_reg;
                        any_pushed_reg <= 1'b1;
                        if (!same_row)
                        begin
                            cur_start_reg <= stored_reg;
                        end
                    end
                end
                S_LOOK_ROW:
                begin
                    state_reg <= S_LOOK_START;
                end
                S_LOOK_START:
                begin
                    cmp_valid_reg <= 1'b0;
                    if (row_in_range && rt_rdata.used)
                    begin
                        p_reg     <= rt_rdata.start_slot;
                        e_reg     <= (rt_rdata.stop_slot > BLOCK_LIMIT) ?
                                     BLOCK_LIMIT : rt_rdata.stop_slot;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                        res_slot_reg   <= '0;
                        state_reg      <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (cmp_valid_reg && (cs_rdata == col_reg))
                    begin
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= OUT_SLOT_W'(cmp_slot_reg);
                        state_reg      <= S_DONE;
                    end
                    else if (p_reg >= e_reg)
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                        res_slot_reg   <= '0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b1;
                        cmp_slot_reg  <= p_reg[SLOT_W-1:0];
                        p_reg         <= p_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_slot_reg   <= res_slot_reg;
                        out_offset_reg <= offset_sat;
                        out_count_reg  <= OUT_COUNT_W'(stored_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The block count never passes the capacity of the column store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= BLOCK_LIMIT)
        else $error("block count beyond capacity");

    // The block count only ever grows by one, and only on a push.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stored_reg) |->
            (stored_reg == CNT_W'($past(stored_reg) + 1'b1)) && ($past(state_reg) == S_PUSH))
        else $error("block count moved unexpectedly");

    // A result that is not ok carries no slot and no offset.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.slot == '0) && (rsp.value_offset == '0))
        else $error("rejected result carries a slot");

    // While the row table is being cleared, the block count stays zero and no row counts as pushed.
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> (stored_reg == '0) && !any_pushed_reg)
        else $error("state changed during clearing pass");

endmodule

[tb/bsrit_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsrit_tb_pkg
// Result tracker for the block sparse row index table unit. It keeps its own
// copy of the row table, the column store and the block_size register, works
// out the result beat of every accepted request and compares each result beat
// against the oldest outstanding answer.
// ----------------------------------------------------------------------------
package bsrit_tb_pkg;

    import bsrit_pkg::*;

    localparam int unsigned BLOCK_SIZE_CAP = 8;
    localparam longint unsigned OFFSET_CEILING = (64'd1 << OFFSET_W) - 1;
    localparam int unsigned REPORT_CAP = 200;

    class bsr_index_tracker;

        typedef struct packed {
            logic [1:0]             status;
            logic [OUT_SLOT_W-1:0]  slot;
            logic [OFFSET_W-1:0]    value_offset;
            logic [OUT_COUNT_W-1:0] block_count;
        } answer_t;

        answer_t          expected_answers[$];
        logic [BS_W-1:0]  block_size;
        bit               row_seen[MAX_ROWS];
        int unsigned      first_slot[MAX_ROWS];
        int unsigned      stop_slot[MAX_ROWS];
        logic [COL_W-1:0] block_columns[BLOCK_CAPACITY];
        int unsigned      blocks_held;
        int unsigned      open_row;
        bit               pushed_once;
        int unsigned      errors;
        int unsigned      pushes;
        int unsigned      lookups;
        int unsigned      results_checked;

        function new();
            block_size      = BS_RESET;
            blocks_held     = 0;
            open_row        = 0;
            pushed_once     = 1'b0;
            errors          = 0;
            pushes          = 0;
            lookups         = 0;
            results_checked = 0;
            foreach (row_seen[i])
            begin
                row_seen[i]   = 1'b0;
                first_slot[i] = 0;
                stop_slot[i]  = 0;
            end
            foreach (block_columns[i])
                block_columns[i] = '0;
        endfunction

        function void set_block_size(logic [DATA_W-1:0] value);
            block_size = value[BS_W-1:0];
        endfunction

        function int unsigned pending();
            return expected_answers.size();
        endfunction

        function logic [OFFSET_W-1:0] offset_for(int unsigned slot);
            longint unsigned b;
            longint unsigned v;
            b = (block_size > BLOCK_SIZE_CAP) ? BLOCK_SIZE_CAP : block_size;
            v = slot * b * b;
            if (v > OFFSET_CEILING)
                v = OFFSET_CEILING;
            return v[OFFSET_W-1:0];
        endfunction

        function void add_answer(logic [1:0] status, int unsigned slot, bit ok);
            answer_t a;
            a.status       = status;
            a.slot         = ok ? slot[OUT_SLOT_W-1:0] : '0;
            a.value_offset = ok ? offset_for(slot) : '0;
            a.block_count  = blocks_held[OUT_COUNT_W-1:0];
            expected_answers.push_back(a);
        endfunction

        function void note_request(logic op, logic [ROW_W-1:0] row, logic [COL_W-1:0] column);
            int unsigned p;
            int unsigned stop;
            int unsigned slot;
            if (op == OP_PUSH)
            begin
                pushes++;
                if (row >= MAX_ROWS || (pushed_once && row < open_row))
                    add_answer(ST_ORDER, 0, 1'b0);
                else if (blocks_held >= BLOCK_CAPACITY)
                    add_answer(ST_FULL, 0, 1'b0);
                else
                begin
                    slot                = blocks_held;
                    block_columns[slot] = column;
                    blocks_held++;
                    if (!row_seen[row])
                    begin
                        row_seen[row]   = 1'b1;
                        first_slot[row] = slot;
                    end
                    stop_slot[row] = blocks_held;
                    open_row       = row;
                    pushed_once    = 1'b1;
                    add_answer(ST_OK, slot, 1'b1);
                end
                return;
            end
            lookups++;
            if (row < MAX_ROWS && row_seen[row])
            begin
                stop = (stop_slot[row] > BLOCK_CAPACITY) ? BLOCK_CAPACITY : stop_slot[row];
                for (p = first_slot[row]; p < stop; p++)
                begin
                    if (block_columns[p] == column)
                    begin
                        add_answer(ST_OK, p, 1'b1);
                        return;
                    end
                end
            end
            add_answer(ST_NOT_FOUND, 0, 1'b0);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        function void check_result(logic [1:0] status, logic [OUT_SLOT_W-1:0] slot,
                                   logic [OFFSET_W-1:0] value_offset,
                                   logic [OUT_COUNT_W-1:0] block_count);
            answer_t want;
            if (expected_answers.size() == 0)
            begin
                errors++;
                $error("result beat arrived with no request outstanding");
                return;
            end
            want = expected_answers.pop_front();
            results_checked++;
            compare("status", 32'(want.status), 32'(status));
            compare("slot", 32'(want.slot), 32'(slot));
            compare("value_offset", 32'(want.value_offset), 32'(value_offset));
            compare("block_count", 32'(want.block_count), 32'(block_count));
        endfunction

    endclass

endpackage

[tb/block_sparse_row_index_table_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_sparse_row_index_table_unit_tb
// Drives request beats into the index table unit with bursty timing while the
// result side stalls on shifting patterns and two long hold-offs. Starts with
// hand-picked pushes and lookups, runs random phases under several block
// sizes, then probes the newest row with clamped block sizes.
// Every result beat is checked against an independent prediction.
// ----------------------------------------------------------------------------
module block_sparse_row_index_table_unit_tb;

    import bsrit_pkg::*;
    import bsrit_tb_pkg::*;

    localparam int unsigned CLK_PERIOD     = 12;
    localparam longint unsigned TIMEOUT_CYCLES = 5_000_000;
    localparam int unsigned RANDOM_PHASES  = 6;
    localparam int unsigned PHASE_ITEMS    = 200;
    localparam int unsigned ROW_CEILING    = 700;
    localparam int unsigned SETTLE_CYCLES  = 100;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned FIRST_HOLD_AT  = 400;
    localparam int unsigned SECOND_HOLD_AT = 1000;
    localparam logic [ADDR_W-1:0] ADDR_BLOCK_SIZE = {REG_BLOCK_SIZE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPARE      = {~REG_BLOCK_SIZE, 2'b00};

    typedef enum int unsigned {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_MOSTLY
    } ready_mode_e;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bsrit_req_if req_ch ();
    bsrit_rsp_if rsp_ch ();

    block_sparse_row_index_table_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bsr_index_tracker sb;
    int unsigned burst_left;
    int unsigned gap_max;
    int unsigned burst_max;
    int unsigned settings_used;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic pace();
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
    endtask

    task automatic issue(input logic op, input logic [ROW_W-1:0] row,
                         input logic [COL_W-1:0] column);
        pace();
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.row       <= row;
        req_ch.column    <= column;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(op, row, column);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_block_size_readback();
        logic [DATA_W-1:0] rd;
        cfg_read(ADDR_BLOCK_SIZE, rd);
        sb.compare("block_size readback", 32'(sb.block_size), rd);
    endtask

    task automatic set_block_size(input logic [BS_W-1:0] value);
        logic [DATA_W-1:0] word;
        drain();
        word           = $urandom;
        word[BS_W-1:0] = value;
        cfg_write(ADDR_BLOCK_SIZE, word);
        sb.set_block_size(word);
        settings_used++;
        check_block_size_readback();
    endtask

    task automatic pick_column_in_row(input int unsigned row, output logic [COL_W-1:0] column);
        if (sb.row_seen[row])
            column = sb.block_columns[$urandom_range(sb.first_slot[row], sb.stop_slot[row] - 1)];
        else
            column = COL_W'($urandom);
    endtask

    task automatic pick_random_request(output logic op, output logic [ROW_W-1:0] row,
                                       output logic [COL_W-1:0] column);
        int unsigned roll;
        int unsigned step;
        int unsigned r;
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            step = $urandom_range(0, 99);
            step = (step < 50) ? 0 : (step < 85) ? 1 : $urandom_range(2, 4);
            r = sb.open_row + step;
            if (r > ROW_CEILING)
                r = sb.open_row;
            op  = OP_PUSH;
            row = ROW_W'(r);
            if ($urandom_range(0, 4) == 0 && r == sb.open_row)
                pick_column_in_row(r, column);
            else
                column = COL_W'($urandom);
        end
        else if (roll < 75)
        begin
            r   = $urandom_range(0, sb.open_row);
            op  = OP_LOOKUP;
            row = ROW_W'(r);
            pick_column_in_row(r, column);
        end
        else if (roll < 88 || sb.open_row == 0)
        begin
            op     = OP_LOOKUP;
            row    = ROW_W'($urandom);
            column = COL_W'($urandom);
        end
        else
        begin
            op     = OP_PUSH;
            row    = ROW_W'($urandom_range(0, sb.open_row - 1));
            column = COL_W'($urandom);
        end
    endtask

    initial
    begin : result_sink
        ready_mode_e mode;
        int unsigned mode_left;
        int unsigned phase_cnt;
        int unsigned period;
        int unsigned duty;
        int unsigned hold_left;
        bit          first_hold_done;
        bit          second_hold_done;
        logic        next_ready;
        rsp_ch.ready <= 1'b0;
        mode             = READY_ALWAYS;
        mode_left        = 0;
        phase_cnt        = 0;
        period           = 2;
        duty             = 1;
        hold_left        = 0;
        first_hold_done  = 1'b0;
        second_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.slot, rsp_ch.value_offset,
                                rsp_ch.block_count);
            if (hold_left == 0 && !first_hold_done && sb.results_checked >= FIRST_HOLD_AT)
            begin
                hold_left       = HOLD_CYCLES;
                first_hold_done = 1'b1;
            end
            if (hold_left == 0 && !second_hold_done && sb.results_checked >= SECOND_HOLD_AT)
            begin
                hold_left        = HOLD_CYCLES;
                second_hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = ready_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                    period    = $urandom_range(2, 9);
                    duty      = $urandom_range(1, period - 1);
                    phase_cnt = 0;
                end
                mode_left--;
                phase_cnt++;
                case (mode)
                    READY_ALWAYS:   next_ready = 1'b1;
                    READY_COIN:     next_ready = 1'($urandom_range(0, 1));
                    READY_PERIODIC: next_ready = (phase_cnt % period) < duty;
                    default:        next_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
            rsp_ch.ready <= next_ready;
        end
    end

    initial
    begin : stimulus
        logic              op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        int unsigned       phase;
        int unsigned       n;
        logic [BS_W-1:0]   phase_sizes[RANDOM_PHASES];

        sb            = new();
        settings_used = 1;
        burst_left    = 0;
        gap_max       = 6;
        burst_max     = 12;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_PUSH;
        req_ch.row       <= '0;
        req_ch.column    <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        check_block_size_readback();

        issue(OP_LOOKUP, 10'd0, 10'd0);
        issue(OP_PUSH, 10'd0, 10'd0);
        issue(OP_PUSH, 10'd0, 10'd1023);
        issue(OP_LOOKUP, 10'd0, 10'd1023);
        issue(OP_LOOKUP, 10'd0, 10'd512);
        issue(OP_PUSH, 10'd2, 10'd5);
        issue(OP_PUSH, 10'd2, 10'd5);
        issue(OP_PUSH, 10'd2, 10'd682);
        issue(OP_LOOKUP, 10'd2, 10'd5);
        issue(OP_LOOKUP, 10'd1, 10'd0);
        issue(OP_PUSH, 10'd1, 10'd9);
        issue(OP_PUSH, 10'd0, 10'd1);
        issue(OP_LOOKUP, 10'd1023, 10'd1023);
        issue(OP_PUSH, 10'd2, 10'd341);
        issue(OP_LOOKUP, 10'd2, 10'd341);
        issue(OP_LOOKUP, 10'd0, 10'd0);
        issue(OP_PUSH, 10'd5, 10'd0);
        issue(OP_LOOKUP, 10'd5, 10'd0);
        issue(OP_LOOKUP, 10'd682, 10'd341);
        issue(OP_LOOKUP, 10'd2, 10'd682);

        drain();
        cfg_write(ADDR_SPARE, $urandom);
        check_block_size_readback();

        phase_sizes[0] = 4'd1;
        phase_sizes[1] = 4'd8;
        phase_sizes[2] = 4'd0;
        phase_sizes[3] = 4'd15;
        phase_sizes[4] = BS_W'($urandom_range(0, 15));
        phase_sizes[5] = BS_W'($urandom_range(1, 8));
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_block_size(phase_sizes[phase]);
            gap_max   = (phase % 2 == 0) ? 8 : 2;
            burst_max = (phase % 2 == 0) ? 10 : 40;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_random_request(op, row, column);
                issue(op, row, column);
            end
        end

        set_block_size(4'd8);
        gap_max   = 6;
        burst_max = 12;
        issue(OP_PUSH, ROW_W'(sb.open_row), COL_W'($urandom));
        issue(OP_PUSH, 10'd0, COL_W'($urandom));
        issue(OP_LOOKUP, ROW_W'(sb.open_row), sb.block_columns[sb.blocks_held - 1]);
        for (n = 0; n < 30; n++)
        begin
            pick_random_request(op, row, column);
            issue(op, row, column);
        end
        set_block_size(4'd15);
        issue(OP_LOOKUP, ROW_W'(sb.open_row), sb.block_columns[sb.blocks_held - 1]);
        for (n = 0; n < 10; n++)
        begin
            pick_random_request(op, row, column);
            issue(op, row, column);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d result beats: %0d pushes and %0d lookups under %0d block_size settings.",
                 sb.results_checked, sb.pushes, sb.lookups, settings_used);
        $display("Column store reached %0d of %0d blocks; rows used up to %0d.",
                 sb.blocks_held, BLOCK_CAPACITY, sb.open_row);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
design/bsrit_pkg.sv
design/bsrit_ifs.sv
design/bsrit_ram.sv
design/block_sparse_row_index_table_unit.sv
tb/bsrit_tb_pkg.sv
tb/block_sparse_row_index_table_unit_tb.sv
